// ===== design/gc_pkg.sv =====
package gc_pkg;

    localparam int SAMPLE_BITS     = 8;
    localparam int GAMMA_BITS      = 16;
    localparam int GAMMA_FRAC_BITS = 12;
    localparam int LOG_FRAC        = 28;
    localparam int MANT_FRAC       = 30;
    localparam int LOG_W           = LOG_FRAC + 3;
    localparam int MANT_W          = MANT_FRAC + 1;
    localparam int Q_W             = LOG_W + GAMMA_BITS - GAMMA_FRAC_BITS;
    localparam int IPART_W         = Q_W - LOG_FRAC;
    localparam int IP_W            = IPART_W + 2;
    localparam int V_W             = SAMPLE_BITS + MANT_W;
    localparam int VS_W            = V_W + SAMPLE_BITS;
    localparam int NUM_SAMPLES     = 1 << SAMPLE_BITS;
    localparam int EXP_STEPS       = LOG_FRAC;
    localparam int LATENCY         = EXP_STEPS + 5;
    localparam int CH_W            = 2;
    localparam int CFG_W           = 16;

    typedef enum logic [1:0] {
        CFG_GAMMA    = 2'd0,
        CFG_MAX      = 2'd1,
        CFG_CHANNELS = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        SPEC_NONE,
        SPEC_ZERO,
        SPEC_MAXV
    } spec_t;

    typedef logic [NUM_SAMPLES-1:0][LOG_W-1:0] log_tbl_t;
    typedef logic [EXP_STEPS:1][MANT_W-1:0] exp_tbl_t;

    // Truncated log2 with LOG_FRAC fraction bits, found by repeated squaring.
    function automatic logic [LOG_W-1:0] log2_fix(input logic [63:0] x);
        logic [63:0] m;
        logic [63:0] frac;
        int          n;
        n = 0;
        for (int i = 0; i < 16; i++) begin
            if ((x >> (i + 1)) != 0) begin
                n = i + 1;
            end
        end
        m    = x << (MANT_FRAC - n);
        frac = '0;
        for (int k = 0; k < LOG_FRAC; k++) begin
            m    = (m * m) >> MANT_FRAC;
            frac = frac << 1;
            if (m >= (64'd2 << MANT_FRAC)) begin
                m    = m >> 1;
                frac = frac | 64'd1;
            end
        end
        return LOG_W'((64'(n) << LOG_FRAC) | frac);
    endfunction

    function automatic log_tbl_t build_log_tbl();
        log_tbl_t t;
        t = '0;
        for (int i = 1; i < NUM_SAMPLES; i++) begin
            t[i] = log2_fix(64'(i));
        end
        return t;
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = '0;
        b = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (b > v) begin
                b = b >> 2;
            end
        end
        for (int i = 0; i < 32; i++) begin
            if (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // Factors 2^(2^-k) in Q1.30, each the square root of the one before.
    function automatic exp_tbl_t build_exp_tbl();
        exp_tbl_t    t;
        logic [63:0] prev;
        prev = 64'd2 << MANT_FRAC;
        for (int k = 1; k <= EXP_STEPS; k++) begin
            prev = isqrt64(prev << MANT_FRAC);
            t[k] = MANT_W'(prev);
        end
        return t;
    endfunction

    localparam log_tbl_t LOG_TBL = build_log_tbl();
    localparam exp_tbl_t EXP_TBL = build_exp_tbl();

endpackage

// ===== design/gc_exp_step.sv =====
module gc_exp_step
    import gc_pkg::*;
#(
    parameter logic [MANT_W-1:0] FACTOR = '0
)
(
    input  logic              clk,
    input  logic              en,
    input  logic              use_bit,
    input  logic [MANT_W-1:0] mant_in,
    output logic [MANT_W-1:0] mant_out
);

    logic [2*MANT_W-1:0] prod;
    logic [MANT_W-1:0]   mant_reg;
    logic [MANT_W-1:0]   mant_next;

    // One factor of the 2^f product, truncated back to Q1.30.
    assign prod      = mant_in * FACTOR;
    assign mant_next = use_bit ? prod[MANT_FRAC +: MANT_W] : mant_in;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mant_reg <= mant_next;
        end
    end

    assign mant_out = mant_reg;

endmodule

// ===== design/gc_lane.sv =====
module gc_lane
    import gc_pkg::*;
#(
    parameter int LANE = 0
)
(
    input  logic                   clk,
    input  logic                   en,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic [GAMMA_BITS-1:0]  gamma,
    input  logic [SAMPLE_BITS-1:0] max_value,
    input  logic [CH_W-1:0]        channel_count,
    output logic [SAMPLE_BITS-1:0] result
);

    // Stage 1: log difference.
    logic [LOG_W-1:0]       ls;
    logic [LOG_W-1:0]       lm;
    logic                   active;
    spec_t                  s1_spec_next;
    logic [LOG_W-1:0]       s1_mag_reg;
    logic [LOG_W-1:0]       s1_mag_next;
    logic                   s1_neg_reg;
    logic                   s1_neg_next;
    spec_t                  s1_spec_reg;

    // Stage 2: scale by gamma.
    logic [LOG_W+GAMMA_BITS-1:0] s2_prod;
    logic [Q_W-1:0]              s2_q_reg;
    logic [Q_W-1:0]              s2_q_next;
    logic                        s2_neg_reg;
    spec_t                       s2_spec_reg;

    // Stage 3: integer and fraction split.
    logic [IPART_W-1:0]     ipart;
    logic [LOG_FRAC-1:0]    fpart;
    logic signed [IP_W-1:0] s3_ip_next;
    logic [LOG_FRAC-1:0]    s3_f_next;

    // Exponent chain.
    logic [MANT_W-1:0]      mant_st [EXP_STEPS+1];
    logic [MANT_W-1:0]      mant0_reg;
    logic [LOG_FRAC-1:0]    f_st_reg [EXP_STEPS+1];
    logic signed [IP_W-1:0] ip_st_reg [EXP_STEPS+1];
    spec_t                  spec_st_reg [EXP_STEPS+1];

    // Scale by M, then shift and round.
    logic [V_W-1:0]         v_reg;
    logic [V_W-1:0]         v_next;
    logic signed [IP_W-1:0] v_ip_reg;
    spec_t                  v_spec_reg;
    logic [VS_W-1:0]        vs;
    logic [VS_W:0]          biased;
    logic [VS_W-MANT_FRAC:0] w;
    logic [SAMPLE_BITS-1:0] res_reg;
    logic [SAMPLE_BITS-1:0] res_next;

    assign active = channel_count > CH_W'(LANE);
    assign ls     = LOG_TBL[sample];
    assign lm     = LOG_TBL[max_value];

    always_comb
    begin
        s1_neg_next = ls < lm;
        s1_mag_next = s1_neg_next ? (lm - ls) : (ls - lm);
        if (!active || max_value == '0)
        begin
            s1_spec_next = SPEC_ZERO;
        end
        else if (gamma == '0)
        begin
            s1_spec_next = SPEC_MAXV;
        end
        else if (sample == '0)
        begin
            s1_spec_next = SPEC_ZERO;
        end
        else
        begin
            s1_spec_next = SPEC_NONE;
        end
    end

    assign s2_prod   = s1_mag_reg * gamma;
    assign s2_q_next = s2_prod[GAMMA_FRAC_BITS +: Q_W];

    assign ipart = s2_q_reg[LOG_FRAC +: IPART_W];
    assign fpart = s2_q_reg[LOG_FRAC-1:0];

    always_comb
    begin
        if (s2_neg_reg && fpart != '0)
        begin
            s3_ip_next = -$signed(IP_W'(ipart)) - IP_W'(1);
            s3_f_next  = LOG_FRAC'(({1'b1, {LOG_FRAC{1'b0}}}) - {1'b0, fpart});
        end
        else if (s2_neg_reg)
        begin
            s3_ip_next = -$signed(IP_W'(ipart));
            s3_f_next  = fpart;
        end
        else
        begin
            s3_ip_next = $signed(IP_W'(ipart));
            s3_f_next  = fpart;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_mag_reg     <= s1_mag_next;
            s1_neg_reg     <= s1_neg_next;
            s1_spec_reg    <= s1_spec_next;
            s2_q_reg       <= s2_q_next;
            s2_neg_reg     <= s1_neg_reg;
            s2_spec_reg    <= s1_spec_reg;
            mant0_reg      <= MANT_W'(1) << MANT_FRAC;
            f_st_reg[0]    <= s3_f_next;
            ip_st_reg[0]   <= s3_ip_next;
            spec_st_reg[0] <= s2_spec_reg;
            for (int j = 0; j < EXP_STEPS; j++)
            begin
                f_st_reg[j+1]    <= f_st_reg[j];
                ip_st_reg[j+1]   <= ip_st_reg[j];
                spec_st_reg[j+1] <= spec_st_reg[j];
            end
            v_reg      <= v_next;
            v_ip_reg   <= ip_st_reg[EXP_STEPS];
            v_spec_reg <= spec_st_reg[EXP_STEPS];
            res_reg    <= res_next;
        end
    end

    assign mant_st[0] = mant0_reg;

    for (genvar j = 0; j < EXP_STEPS; j++)
    begin : g_exp
        gc_exp_step #(
            .FACTOR (EXP_TBL[j+1])
        ) u_step (
            .clk      (clk),
            .en       (en),
            .use_bit  (f_st_reg[j][LOG_FRAC-1-j]),
            .mant_in  (mant_st[j]),
            .mant_out (mant_st[j+1])
        );
    end

    assign v_next = max_value * mant_st[EXP_STEPS];

    always_comb
    begin
        vs = '0;
        if (v_ip_reg >= 0)
        begin
            vs = VS_W'(v_reg) << v_ip_reg[IP_W-2:0];
        end
        else if (v_ip_reg > -$signed(IP_W'(63)))
        begin
            vs = VS_W'(v_reg) >> (-v_ip_reg);
        end
        biased = {1'b0, vs} + ((VS_W+1)'(1) << (MANT_FRAC - 12));
        w      = biased[VS_W:MANT_FRAC];
        unique case (v_spec_reg)
            SPEC_ZERO: res_next = '0;
            SPEC_MAXV: res_next = max_value;
            default:
            begin
                if (v_ip_reg >= $signed(IP_W'(SAMPLE_BITS)))
                begin
                    res_next = '1;
                end
                else if (w > (VS_W-MANT_FRAC+1)'({SAMPLE_BITS{1'b1}}))
                begin
                    res_next = '1;
                end
                else
                begin
                    res_next = w[SAMPLE_BITS-1:0];
                end
            end
        endcase
    end

    assign result = res_reg;

endmodule

// ===== design/pixel_gamma_correction.sv =====
// Power-law gamma correction for a stream of pixels of up to three 8-bit
// channels. Each active sample s becomes floor(M * (s/M)^g), computed as
// M * 2^(g * (log2 s - log2 M)) in fixed point, where M is max_value and g is
// the unsigned Q4.12 gamma; results saturate at 255, inactive channels give 0,
// and the last-pixel flag rides along unchanged. The block takes one pixel per
// clock unless the output stalls. Each result passes through five stages for
// the log lookup, the gamma multiply, the exponent split, the scale by M and
// the final round, with the 2^f chain between the split and the scale; that
// chain applies one multiplier stage per fraction bit of the exponent (28
// stages). A stall at the output freezes the whole pipeline. Configuration
// registers are written through the cfg port, which is always ready, and must
// only be changed while no pixel is in flight.
module pixel_gamma_correction
    import gc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [1:0]             cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SAMPLE_BITS-1:0] sample_a,
    input  logic [SAMPLE_BITS-1:0] sample_b,
    input  logic [SAMPLE_BITS-1:0] sample_c,
    input  logic                   last_pixel,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [SAMPLE_BITS-1:0] result_a,
    output logic [SAMPLE_BITS-1:0] result_b,
    output logic [SAMPLE_BITS-1:0] result_c,
    output logic                   last_out
);

    logic [GAMMA_BITS-1:0]  gamma_reg;
    logic [SAMPLE_BITS-1:0] max_reg;
    logic [CH_W-1:0]        chan_reg;
    logic [LATENCY-1:0]     vld_reg;
    logic [LATENCY-1:0]     vld_next;
    logic [LATENCY-1:0]     last_reg;
    logic                   en;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gamma_reg <= GAMMA_BITS'(1) << GAMMA_FRAC_BITS;
            max_reg   <= '1;
            chan_reg  <= CH_W'(3);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_GAMMA:    gamma_reg <= cfg_data;
                CFG_MAX:      max_reg   <= cfg_data[SAMPLE_BITS-1:0];
                CFG_CHANNELS: chan_reg  <= cfg_data[CH_W-1:0];
                default:      ;
            endcase
        end
    end

    // The whole pipeline advances together unless the output holds a result
    // that has not been taken.
    assign en       = !vld_reg[LATENCY-1] || out_ready;
    assign in_ready = en;
    assign vld_next = {vld_reg[LATENCY-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            last_reg <= {last_reg[LATENCY-2:0], last_pixel};
        end
    end

    gc_lane #(.LANE(0)) u_lane_a (
        .clk (clk), .en (en), .sample (sample_a), .gamma (gamma_reg),
        .max_value (max_reg), .channel_count (chan_reg), .result (result_a)
    );

    gc_lane #(.LANE(1)) u_lane_b (
        .clk (clk), .en (en), .sample (sample_b), .gamma (gamma_reg),
        .max_value (max_reg), .channel_count (chan_reg), .result (result_b)
    );

    gc_lane #(.LANE(2)) u_lane_c (
        .clk (clk), .en (en), .sample (sample_c), .gamma (gamma_reg),
        .max_value (max_reg), .channel_count (chan_reg), .result (result_c)
    );

    assign out_valid = vld_reg[LATENCY-1];
    assign last_out  = last_reg[LATENCY-1];

    // The input side only stalls because of the output side.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled without output backpressure");

    // Grey pixels leave the second and third channels at zero.
    a_grey_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && chan_reg == CH_W'(1)) |-> (result_b == '0 && result_c == '0))
        else $error("inactive channel not zero");

    // A zero gamma maps every active sample to the maximum value.
    a_gamma_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && gamma_reg == '0 && chan_reg != '0) |-> (result_a == max_reg))
        else $error("zero gamma did not give max value");

endmodule
